>>> rtl/bfa_pkg.sv
// Shared constants for the bitmap frame allocator.
// Holds the sizes of the frame bitmap, the request kinds and the register indexes.
// No dependencies.
package bfa_pkg;

    localparam int MAX_FRAMES    = 65536;
    localparam int MAP_WORD_BITS = 32;
    localparam int PAGE_SHIFT    = 12;

    localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIDX_W    = $clog2(MAP_WORD_BITS);
    localparam int FRAME_W   = $clog2(MAX_FRAMES) + 1;

    localparam int ADDR_W  = 48;
    localparam int CNT_W   = 17;
    localparam int KIND_W  = 2;
    localparam int TALLY_W = 17;
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

    localparam logic CFG_REGION_BASE    = 1'b0;
    localparam logic CFG_FRAMES_MANAGED = 1'b1;

endpackage

>>> rtl/bfa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the frame bitmap; no package dependencies.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bitmap_frame_allocator.sv
// Top level of the bitmap first-fit page-frame allocator.
// Depends on bfa_pkg for sizes and codes and on bfa_ram for the frame bitmap.
//
// Usage: a request (i_kind, i_address, i_request_count) is taken at a rising edge
// with start high and busy low. busy stays high while the request is worked on.
// Exactly one result per request is shown for one cycle with o_valid high;
// the receiver cannot stall, so the result must be captured in that cycle.
// The user writes configuration (i_cfg_we, i_cfg_index, i_cfg_data) only while idle; the block does not enforce it.
//
// Sequencing: the bitmap is one RAM word of 32 frames per address, and one
// sequencer walks it. Free and reserve read and then write back each bitmap
// word spanned, then update the tallies. Allocate scans from word 0: a fully
// used or fully free word is judged whole, a mixed word one frame per cycle,
// then the found run is marked word by word and the tallies updated. A failed
// allocate ends after its scan; a request that touches no word goes to done.
// The result strobe is registered from the done state.
//
// Reset: a synchronous active-low reset starts a clearing pass that writes
// all 2048 bitmap words, one per cycle; busy is high during the pass.
module bitmap_frame_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bfa_pkg::KIND_W-1:0]  i_kind,
    input  logic [bfa_pkg::ADDR_W-1:0]  i_address,
    input  logic [bfa_pkg::CNT_W-1:0]   i_request_count,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [bfa_pkg::ADDR_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic [bfa_pkg::ADDR_W-1:0]  o_frame_address,
    output logic [bfa_pkg::TALLY_W-1:0] o_used_count,
    output logic [bfa_pkg::TALLY_W-1:0] o_free_count,
    output logic [bfa_pkg::TALLY_W-1:0] o_reserved_count
);

    localparam int FW = bfa_pkg::FRAME_W;
    localparam int WW = bfa_pkg::WIDX_W;
    localparam int BW = bfa_pkg::BIDX_W;
    localparam int MB = bfa_pkg::MAP_WORD_BITS;
    localparam int AW = bfa_pkg::ADDR_W;
    localparam int TW = bfa_pkg::TALLY_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SEVAL = 4'd3;
    localparam logic [3:0] S_SBIT  = 4'd4;
    localparam logic [3:0] S_MRD   = 4'd5;
    localparam logic [3:0] S_MWR   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    function automatic logic [BW:0] popcount(input logic [MB-1:0] v);
        logic [BW:0] c;
        c = '0;
        for (int k = 0; k < MB; k++) begin
            c = c + {{BW{1'b0}}, v[k]};
        end
        return c;
    endfunction

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? bfa_pkg::TALLY_MAX : s[TW-1:0];
    endfunction

    logic [3:0]                   r_state, n_state;
    logic [WW-1:0]                r_word, n_word;
    logic [WW-1:0]                r_last_w, n_last_w;
    logic [FW-1:0]                r_lo, n_lo;
    logic [FW-1:0]                r_hi, n_hi;
    logic [bfa_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [bfa_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [FW-1:0]                r_run, n_run;
    logic [FW-1:0]                r_start, n_start;
    logic [MB-1:0]                r_bits, n_bits;
    logic [BW-1:0]                r_bit, n_bit;
    logic [FW-1:0]                r_acc, n_acc;
    logic                         r_ok, n_ok;
    logic [AW-1:0]                r_faddr, n_faddr;
    logic [TW-1:0]                r_used, n_used;
    logic [TW-1:0]                r_resv, n_resv;
    logic [AW-1:0]                r_base;
    logic [bfa_pkg::CNT_W-1:0]    r_frames;
    logic                         r_valid;
    logic                         r_o_ok;
    logic [AW-1:0]                r_o_faddr;
    logic [TW-1:0]                r_o_used, r_o_free, r_o_resv;

    logic [FW-1:0]   w_total;
    logic [AW:0]     w_end;
    logic            w_in_range;
    logic [AW-1:0]   w_off;
    logic [FW-1:0]   w_first;
    logic [FW:0]     w_last;
    logic [FW-1:0]   w_last_c;
    logic [MB-1:0]   w_rdata;
    logic [MB-1:0]   w_beyond;
    logic [MB-1:0]   w_eff;
    logic [FW-1:0]   w_wbase;
    logic [FW:0]     w_sum32;
    logic [FW:0]     w_run1;
    logic [FW-1:0]   w_fb;
    logic [FW-1:0]   w_hi_m1;
    logic [WW-1:0]   w_lo_w, w_hi_w;
    logic [MB-1:0]   w_mask;
    logic            w_set;
    logic [MB-1:0]   w_changed;
    logic [MB-1:0]   w_new;
    logic            w_we;
    logic [MB-1:0]   w_wdata;
    logic            w_found;
    logic [FW-1:0]   w_found_st;
    logic            w_next_word;

    bfa_ram #(
        .WIDTH (MB),
        .DEPTH (bfa_pkg::MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_word),
        .i_wdata (w_wdata),
        .i_raddr (r_word),
        .o_rdata (w_rdata)
    );

    // Managed count is clipped to the bitmap size.
    assign w_total = (FW'(r_frames) > FW'(bfa_pkg::MAX_FRAMES)) ?
                     FW'(bfa_pkg::MAX_FRAMES) : FW'(r_frames);

    assign w_end      = {1'b0, r_base} + ((AW+1)'(w_total) << bfa_pkg::PAGE_SHIFT);
    assign w_in_range = (i_address >= r_base) && ({1'b0, i_address} < w_end);
    assign w_off      = i_address - r_base;
    assign w_first    = FW'(w_off >> bfa_pkg::PAGE_SHIFT);
    assign w_last     = {1'b0, w_first} + (FW+1)'(i_request_count);
    assign w_last_c   = (w_last > {1'b0, w_total}) ? w_total : w_last[FW-1:0];

    // Frames past the managed count read as used during the scan.
    assign w_beyond = ((r_word == r_last_w) && (w_total[BW-1:0] != '0)) ?
                      ({MB{1'b1}} << w_total[BW-1:0]) : '0;
    assign w_eff    = w_rdata | w_beyond;
    assign w_wbase  = FW'({r_word, {BW{1'b0}}});
    assign w_sum32  = {1'b0, r_run} + (FW+1)'(MB);
    assign w_run1   = {1'b0, r_run} + (FW+1)'(1);
    assign w_fb     = w_wbase | FW'(r_bit);

    assign w_hi_m1 = r_hi - FW'(1);
    assign w_lo_w  = WW'(r_lo >> BW);
    assign w_hi_w  = WW'(w_hi_m1 >> BW);

    always_comb begin
        w_mask = {MB{1'b1}};
        if (r_word == w_lo_w) begin
            w_mask = w_mask & ({MB{1'b1}} << r_lo[BW-1:0]);
        end
        if (r_word == w_hi_w) begin
            w_mask = w_mask & ({MB{1'b1}} >> (BW'(MB - 1) - w_hi_m1[BW-1:0]));
        end
    end

    assign w_set     = (r_kind != bfa_pkg::KIND_FREE);
    assign w_changed = w_set ? (w_mask & ~w_rdata) : (w_mask & w_rdata);
    assign w_new     = w_set ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
    assign w_we      = (r_state == S_CLEAR) || (r_state == S_MWR);
    assign w_wdata   = (r_state == S_CLEAR) ? '0 : w_new;

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_last_w = r_last_w;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_kind   = r_kind;
        n_cnt    = r_cnt;
        n_run    = r_run;
        n_start  = r_start;
        n_bits   = r_bits;
        n_bit    = r_bit;
        n_acc    = r_acc;
        n_ok     = r_ok;
        n_faddr  = r_faddr;
        n_used   = r_used;
        n_resv   = r_resv;
        w_found    = 1'b0;
        w_found_st = r_start;
        w_next_word = 1'b0;

        case (r_state)
            S_CLEAR: begin
                n_word = r_word + WW'(1);
                if (r_word == WW'(bfa_pkg::MAP_WORDS - 1)) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_cnt   = i_request_count;
                    n_ok    = 1'b0;
                    n_faddr = '0;
                    n_acc   = '0;
                    n_run   = '0;
                    n_state = S_DONE;
                    case (i_kind)
                        bfa_pkg::KIND_ALLOC: begin
                            if ((i_request_count != '0) && (w_total != '0)) begin
                                n_word   = '0;
                                n_last_w = WW'((w_total - FW'(1)) >> BW);
                                n_state  = S_SRD;
                            end
                        end
                        bfa_pkg::KIND_FREE, bfa_pkg::KIND_RESERVE: begin
                            n_ok = w_in_range;
                            if (w_in_range && (w_first < w_last_c)) begin
                                n_lo    = w_first;
                                n_hi    = w_last_c;
                                n_word  = WW'(w_first >> BW);
                                n_state = S_MRD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SRD: begin
                n_state = S_SEVAL;
            end
            S_SEVAL: begin
                if (&w_eff) begin
                    n_run       = '0;
                    w_next_word = 1'b1;
                end else if (w_eff == '0) begin
                    if (w_sum32 >= (FW+1)'(r_cnt)) begin
                        w_found    = 1'b1;
                        w_found_st = (r_run == '0) ? w_wbase : r_start;
                    end else begin
                        n_run       = w_sum32[FW-1:0];
                        n_start     = (r_run == '0) ? w_wbase : r_start;
                        w_next_word = 1'b1;
                    end
                end else begin
                    n_bits  = w_eff;
                    n_bit   = '0;
                    n_state = S_SBIT;
                end
            end
            S_SBIT: begin
                if (!r_bits[r_bit]) begin
                    if (w_run1 == (FW+1)'(r_cnt)) begin
                        w_found    = 1'b1;
                        w_found_st = (r_run == '0) ? w_fb : r_start;
                    end else begin
                        n_run   = w_run1[FW-1:0];
                        n_start = (r_run == '0) ? w_fb : r_start;
                    end
                end else begin
                    n_run = '0;
                end
                if (!w_found) begin
                    if (&r_bit) begin
                        w_next_word = 1'b1;
                    end else begin
                        n_bit = r_bit + BW'(1);
                    end
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                n_acc = r_acc + FW'(popcount(w_changed));
                if (r_word == w_hi_w) begin
                    n_state = S_FIN;
                end else begin
                    n_word  = r_word + WW'(1);
                    n_state = S_MRD;
                end
            end
            S_FIN: begin
                case (r_kind)
                    bfa_pkg::KIND_ALLOC: begin
                        n_used = sat_add(r_used, TW'(r_cnt));
                    end
                    bfa_pkg::KIND_FREE: begin
                        n_used = (r_used >= TW'(r_acc)) ? (r_used - TW'(r_acc)) : '0;
                    end
                    default: begin
                        n_used = sat_add(r_used, TW'(r_acc));
                        n_resv = sat_add(r_resv, TW'(r_acc));
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_found) begin
            n_lo    = w_found_st;
            n_hi    = w_found_st + FW'(r_cnt);
            n_word  = WW'(w_found_st >> BW);
            n_ok    = 1'b1;
            n_faddr = r_base + (AW'(w_found_st) << bfa_pkg::PAGE_SHIFT);
            n_state = S_MRD;
        end else if (w_next_word) begin
            if (r_word == r_last_w) begin
                n_state = S_DONE;
            end else begin
                n_word  = r_word + WW'(1);
                n_state = S_SRD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_word   <= '0;
            r_used   <= '0;
            r_resv   <= '0;
            r_base   <= '0;
            r_frames <= bfa_pkg::CNT_W'(bfa_pkg::MAX_FRAMES);
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_used  <= n_used;
            r_resv  <= n_resv;
            r_valid <= (r_state == S_DONE);
            if (i_cfg_we) begin
                if (i_cfg_index == bfa_pkg::CFG_REGION_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_frames <= i_cfg_data[bfa_pkg::CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_w <= n_last_w;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_kind   <= n_kind;
        r_cnt    <= n_cnt;
        r_run    <= n_run;
        r_start  <= n_start;
        r_bits   <= n_bits;
        r_bit    <= n_bit;
        r_acc    <= n_acc;
        r_ok     <= n_ok;
        r_faddr  <= n_faddr;
        if (r_state == S_DONE) begin
            r_o_ok    <= r_ok;
            r_o_faddr <= r_faddr;
            r_o_used  <= r_used;
            r_o_free  <= (w_total > FW'(r_used)) ? TW'(w_total - FW'(r_used)) : '0;
            r_o_resv  <= r_resv;
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_ok             = r_o_ok;
    assign o_frame_address  = r_o_faddr;
    assign o_used_count     = r_o_used;
    assign o_free_count     = r_o_free;
    assign o_reserved_count = r_o_resv;

    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_DONE)
        else $error("result strobe without a finished request");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_frame_address == '0))
        else $error("failed request reports a nonzero frame address");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_CLEAR) || (r_state == S_MWR)))
        else $error("bitmap written outside clear or mark");

endmodule

>>> test/tb_bitmap_frame_allocator.sv
// Self-checking testbench for the bitmap first-fit page-frame allocator.
// Depends on bfa_pkg and bitmap_frame_allocator; a scoreboard class predicts each
// result from its own copy of the frame bitmap, tallies and registers.
module tb_bitmap_frame_allocator;

    localparam logic [bfa_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic                        ok;
        logic [bfa_pkg::ADDR_W-1:0]  frame_address;
        logic [bfa_pkg::TALLY_W-1:0] used_count;
        logic [bfa_pkg::TALLY_W-1:0] free_count;
        logic [bfa_pkg::TALLY_W-1:0] reserved_count;
    } t_alloc_result;

    class t_frame_scoreboard;
        bit            frame_used [bfa_pkg::MAX_FRAMES];
        longint        used_tally;
        longint        reserved_tally;
        longint        base_reg;
        longint        managed_reg;
        t_alloc_result pending [$];
        int            mismatches;

        function new();
            foreach (frame_used[f]) frame_used[f] = 1'b0;
            used_tally     = 0;
            reserved_tally = 0;
            base_reg       = 0;
            managed_reg    = 65536;
            mismatches     = 0;
        endfunction

        function longint frames_in_use();
            return (managed_reg > bfa_pkg::MAX_FRAMES) ? bfa_pkg::MAX_FRAMES : managed_reg;
        endfunction

        function void write_register(logic idx, logic [bfa_pkg::ADDR_W-1:0] data);
            if (idx == bfa_pkg::CFG_REGION_BASE) base_reg = longint'(data);
            else managed_reg = longint'(data[bfa_pkg::CNT_W-1:0]);
        endfunction

        function longint sat_tally(longint a, longint b);
            return (a + b > bfa_pkg::TALLY_MAX) ? longint'(bfa_pkg::TALLY_MAX) : a + b;
        endfunction

        // Works out the result of an accepted request and updates the bitmap.
        function void note_request(logic [bfa_pkg::KIND_W-1:0] kind,
                                   logic [bfa_pkg::ADDR_W-1:0] addr,
                                   logic [bfa_pkg::CNT_W-1:0] cnt);
            longint        total, region_end, first, last, fresh, run, run_start;
            longint        count;
            bit            found;
            t_alloc_result r;
            total      = frames_in_use();
            region_end = base_reg + (total << bfa_pkg::PAGE_SHIFT);
            count      = longint'(cnt);
            r          = '0;
            if (kind == bfa_pkg::KIND_ALLOC) begin
                if (count != 0) begin
                    run = 0;
                    run_start = 0;
                    found = 1'b0;
                    for (longint f = 0; f < total; f++) begin
                        if (!frame_used[f]) begin
                            if (run == 0) run_start = f;
                            run++;
                            if (run == count) begin
                                found = 1'b1;
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                    if (found) begin
                        for (longint f = run_start; f < run_start + count; f++)
                            frame_used[f] = 1'b1;
                        used_tally      = sat_tally(used_tally, count);
                        r.ok            = 1'b1;
                        r.frame_address = bfa_pkg::ADDR_W'(
                            (base_reg + (run_start << bfa_pkg::PAGE_SHIFT)) & MASK48);
                    end
                end
            end else if (kind == bfa_pkg::KIND_FREE || kind == bfa_pkg::KIND_RESERVE) begin
                if (longint'(addr) >= base_reg && longint'(addr) < region_end) begin
                    first = (longint'(addr) - base_reg) >> bfa_pkg::PAGE_SHIFT;
                    last  = first + count;
                    fresh = 0;
                    r.ok  = 1'b1;
                    if (last > total) last = total;
                    for (longint f = first; f < last; f++) begin
                        if (kind == bfa_pkg::KIND_FREE) begin
                            if (frame_used[f]) begin
                                frame_used[f] = 1'b0;
                                if (used_tally > 0) used_tally--;
                            end
                        end else if (!frame_used[f]) begin
                            frame_used[f] = 1'b1;
                            fresh++;
                        end
                    end
                    if (kind == bfa_pkg::KIND_RESERVE) begin
                        used_tally     = sat_tally(used_tally, fresh);
                        reserved_tally = sat_tally(reserved_tally, fresh);
                    end
                end
            end
            r.used_count     = bfa_pkg::TALLY_W'(used_tally);
            r.free_count     = bfa_pkg::TALLY_W'((total > used_tally) ? total - used_tally : 0);
            r.reserved_count = bfa_pkg::TALLY_W'(reserved_tally);
            pending.push_back(r);
        endfunction

        function void check_result(t_alloc_result got);
            t_alloc_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [bfa_pkg::KIND_W-1:0]    i_kind = bfa_pkg::KIND_ALLOC;
    logic [bfa_pkg::ADDR_W-1:0]    i_address = '0;
    logic [bfa_pkg::CNT_W-1:0]     i_request_count = '0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_index = bfa_pkg::CFG_REGION_BASE;
    logic [bfa_pkg::ADDR_W-1:0]    i_cfg_data = '0;
    logic                          o_valid;
    logic                          o_ok;
    logic [bfa_pkg::ADDR_W-1:0]    o_frame_address;
    logic [bfa_pkg::TALLY_W-1:0]   o_used_count;
    logic [bfa_pkg::TALLY_W-1:0]   o_free_count;
    logic [bfa_pkg::TALLY_W-1:0]   o_reserved_count;

    t_frame_scoreboard sb = new();
    longint            cycle_count = 0;
    int                idle_percent = 0;

    bitmap_frame_allocator dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_request(i_kind, i_address, i_request_count);
        if (i_rst_n && o_valid)
            sb.check_result({o_ok, o_frame_address, o_used_count, o_free_count,
                             o_reserved_count});
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(logic [bfa_pkg::KIND_W-1:0] kind,
                                logic [bfa_pkg::ADDR_W-1:0] addr,
                                logic [bfa_pkg::CNT_W-1:0] cnt);
        int gap;
        @(negedge i_clk);
        i_kind          = kind;
        i_address       = addr;
        i_request_count = cnt;
        start           = 1'b1;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_percent) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(logic idx, logic [bfa_pkg::ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_register(idx, data);
    endtask

    function automatic logic [bfa_pkg::ADDR_W-1:0] any_address();
        return bfa_pkg::ADDR_W'({$urandom, $urandom});
    endfunction

    // Mostly addresses inside the region, at any offset within a page; a few past its end.
    function automatic logic [bfa_pkg::ADDR_W-1:0] region_address();
        longint frame;
        frame = longint'($urandom_range(0, int'(sb.frames_in_use()) + 3));
        return bfa_pkg::ADDR_W'((sb.base_reg + (frame << bfa_pkg::PAGE_SHIFT) +
                                 longint'($urandom_range(0, 4095))) & MASK48);
    endfunction

    function automatic logic [bfa_pkg::CNT_W-1:0] random_count();
        if ($urandom_range(99) < 4) return bfa_pkg::CNT_W'($urandom_range(0, 131071));
        return bfa_pkg::CNT_W'($urandom_range(0, 24));
    endfunction

    task automatic random_requests(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_request(bfa_pkg::KIND_ALLOC, any_address(), random_count());
            else if (pick < 68)
                send_request(bfa_pkg::KIND_FREE, region_address(), random_count());
            else if (pick < 88)
                send_request(bfa_pkg::KIND_RESERVE, region_address(), random_count());
            else if (pick < 96)
                send_request(($urandom_range(1) ? bfa_pkg::KIND_FREE : bfa_pkg::KIND_RESERVE),
                             any_address(), random_count());
            else
                send_request(KIND_UNKNOWN, any_address(), random_count());
        end
    endtask

    task automatic run_phase(logic [bfa_pkg::ADDR_W-1:0] base,
                             logic [bfa_pkg::ADDR_W-1:0] frames, int n, int idle);
        wait_idle();
        write_config(bfa_pkg::CFG_REGION_BASE, base);
        write_config(bfa_pkg::CFG_FRAMES_MANAGED, frames);
        idle_percent = idle;
        random_requests(n);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset configuration, then with a small region.
        send_request(bfa_pkg::KIND_ALLOC, '0, 17'd0);
        send_request(bfa_pkg::KIND_ALLOC, '1, 17'd1);
        send_request(bfa_pkg::KIND_ALLOC, '0, 17'd33);
        send_request(bfa_pkg::KIND_RESERVE, 48'h0000_0000_1FFF, 17'd4);
        send_request(bfa_pkg::KIND_FREE, 48'h0000_0000_5000, 17'd3);
        send_request(bfa_pkg::KIND_FREE, 48'h0000_0000_5000, 17'd3);
        send_request(bfa_pkg::KIND_FREE, '1, 17'd2);
        send_request(bfa_pkg::KIND_RESERVE, 48'h0000_0010_0000, 17'd0);
        send_request(KIND_UNKNOWN, 48'h0000_0000_1000, 17'd5);
        send_request(bfa_pkg::KIND_RESERVE, 48'h0000_0FFF_E000, 17'd10);
        send_request(bfa_pkg::KIND_ALLOC, '0, 17'd65536);
        send_request(bfa_pkg::KIND_FREE, '0, 17'd131071);
        send_request(bfa_pkg::KIND_ALLOC, '0, 17'd65536);
        send_request(bfa_pkg::KIND_ALLOC, '0, 17'd1);
        send_request(bfa_pkg::KIND_FREE, '0, 17'd65536);
        send_request(bfa_pkg::KIND_ALLOC, '0, 17'd131071);
        wait_idle();
        write_config(bfa_pkg::CFG_REGION_BASE, 48'hFFFF_FFFF_E000);
        write_config(bfa_pkg::CFG_FRAMES_MANAGED, 48'd4);
        send_request(bfa_pkg::KIND_ALLOC, '0, 17'd3);
        send_request(bfa_pkg::KIND_ALLOC, '0, 17'd1);
        send_request(bfa_pkg::KIND_RESERVE, 48'hFFFF_FFFF_FFFF, 17'd8);
        send_request(bfa_pkg::KIND_FREE, 48'hFFFF_FFFF_DFFF, 17'd1);
        send_request(bfa_pkg::KIND_FREE, 48'hFFFF_FFFF_E000, 17'd131071);

        run_phase(any_address(), 48'd200, 260, 23);
        run_phase(48'd0, 48'd1024, 200, 23);
        run_phase(48'hFFFF_FFFF_F000, 48'd64, 250, 54);
        run_phase(any_address(), 48'd0, 30, 54);
        run_phase(48'h0000_1000_0000, 48'd131071, 60, 54);
        run_phase(any_address(), 48'd32, 300, 0);
        run_phase(48'h0000_0000_0000, 48'd65536, 120, 0);
        run_phase(48'h0000_0001_2345, 48'd37, 100, 0);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
